### rtl/csda_pkg.sv
// Shared types and constants of the cross-spectral density accumulator.
// No dependencies; used by csda_prod and cross_spectral_density_accumulator.
`default_nettype none

package csda_pkg;

  // Parameter defaults
  localparam int MAX_CHANNELS_DEF = 4;
  localparam int MAX_BINS_DEF     = 512;
  localparam int SAMPLE_BITS_DEF  = 16;

  // Accumulator width and product shift amount width (shift is 4..30)
  localparam int ACC_W   = 48;
  localparam int SHAMT_W = 5;

  // Commands
  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Spectrum selectors
  localparam logic [1:0] SPEC_EXC_EXC   = 2'd0;
  localparam logic [1:0] SPEC_RESP_RESP = 2'd1;
  localparam logic [1:0] SPEC_EXC_RESP  = 2'd2;
  localparam logic [1:0] SPEC_RESP_EXC  = 2'd3;

  // Result status
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLOCK_LOG2 = 2'd0;
  localparam logic [1:0] CFG_NUM_EXC    = 2'd1;
  localparam logic [1:0] CFG_NUM_RESP   = 2'd2;

  // Configuration reset values
  localparam logic [3:0] BLOCK_LOG2_RST = 4'd10;
  localparam logic [2:0] NUM_EXC_RST    = 3'd1;
  localparam logic [2:0] NUM_RESP_RST   = 3'd1;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_SUM,
    ST_ADD,
    ST_WB
  } state_t;

  typedef struct packed {
    logic               bin_zero;
    logic [SHAMT_W-1:0] shamt;
  } prod_ctrl_t;

endpackage

`default_nettype wire

### rtl/csda_prod.sv
// Two-stage complex product a * conj(b), scaled by an arithmetic right shift.
// Uses csda_pkg for the control struct; bin 0 multiplies parts separately.
`default_nettype none

module csda_prod #(
  parameter int SAMPLE_BITS = csda_pkg::SAMPLE_BITS_DEF
) (
  input  wire                            clk,
  input  wire logic signed [SAMPLE_BITS-1:0] a_re,
  input  wire logic signed [SAMPLE_BITS-1:0] a_im,
  input  wire logic signed [SAMPLE_BITS-1:0] b_re,
  input  wire logic signed [SAMPLE_BITS-1:0] b_im,
  input  wire csda_pkg::prod_ctrl_t      ctrl,
  output logic signed [2*SAMPLE_BITS:0]  term_re,
  output logic signed [2*SAMPLE_BITS:0]  term_im
);

  localparam int PW = 2*SAMPLE_BITS;
  localparam int TW = PW + 1;

  logic signed [PW-1:0] pp_rr_r, pp_ii_r, pp_ir_r, pp_ri_r;
  csda_pkg::prod_ctrl_t ctrl_r;
  logic signed [TW-1:0] sum_re, sum_im;
  logic signed [TW-1:0] term_re_nxt, term_im_nxt;
  logic signed [TW-1:0] term_re_r, term_im_r;

  // Stage 1: four independent products
  always_ff @(posedge clk) begin
    pp_rr_r <= a_re * b_re;
    pp_ii_r <= a_im * b_im;
    pp_ir_r <= a_im * b_re;
    pp_ri_r <= a_re * b_im;
    ctrl_r  <= ctrl;
  end

  // Stage 2: combine, then scale (floor shift)
  always_comb begin
    if (ctrl_r.bin_zero) begin
      sum_re = TW'(pp_rr_r);
      sum_im = TW'(pp_ii_r);
    end else begin
      sum_re = TW'(pp_rr_r) + TW'(pp_ii_r);
      sum_im = TW'(pp_ir_r) - TW'(pp_ri_r);
    end
    term_re_nxt = sum_re >>> ctrl_r.shamt;
    term_im_nxt = sum_im >>> ctrl_r.shamt;
  end

  always_ff @(posedge clk) begin
    term_re_r <= term_re_nxt;
    term_im_r <= term_im_nxt;
  end

  assign term_re = term_re_r;
  assign term_im = term_im_r;

endmodule

`default_nettype wire

### rtl/cross_spectral_density_accumulator.sv
// Top level of the cross-spectral density accumulator: config registers,
// sequencer, entry memory and saturating accumulate. Uses csda_pkg, csda_prod.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------------
//  config    cfg_we, cfg_index, cfg_wdata            write when cfg_we is high
//  request   start, busy, in_command .. in_b_im      taken when start && !busy
//  result    out_strobe, out_acc_re/im, out_status   valid for the strobe cycle only
//
// A request steps through memory read with the products, sum and shift, accumulate
// and write back; the result strobes in the write-back state, and a new request is
// taken in that same cycle. The read-modify-write of the entry memory around the
// two-stage product sets these steps. After reset a clearing pass zeroes all
// 4*MAX_CHANNELS^2*MAX_BINS entries with busy high. The receiver cannot stall;
// each result is on the ports for one cycle.
`default_nettype none

module cross_spectral_density_accumulator #(
  parameter int MAX_CHANNELS = csda_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_BINS     = csda_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_BITS  = csda_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [3:0]                     cfg_wdata,
  input  wire                                 start,
  output logic                                busy,
  input  wire logic [1:0]                     in_command,
  input  wire logic [1:0]                     in_spectrum,
  input  wire logic [1:0]                     in_row,
  input  wire logic [1:0]                     in_col,
  input  wire logic [8:0]                     in_bin,
  input  wire logic signed [SAMPLE_BITS-1:0]  in_a_re,
  input  wire logic signed [SAMPLE_BITS-1:0]  in_a_im,
  input  wire logic signed [SAMPLE_BITS-1:0]  in_b_re,
  input  wire logic signed [SAMPLE_BITS-1:0]  in_b_im,
  output logic                                out_strobe,
  output logic signed [csda_pkg::ACC_W-1:0]   out_acc_re,
  output logic signed [csda_pkg::ACC_W-1:0]   out_acc_im,
  output logic [1:0]                          out_status
);

  localparam int ACC_W = csda_pkg::ACC_W;
  localparam int DEPTH = 4*MAX_CHANNELS*MAX_CHANNELS*MAX_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = 2*SAMPLE_BITS + 1;
  localparam int SUM_W = ((TW > ACC_W) ? TW : ACC_W) + 1;
  localparam int MW    = 2*ACC_W;

  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Configuration
  logic [3:0] blk_log2_r;
  logic [2:0] num_exc_r, num_resp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_log2_r <= csda_pkg::BLOCK_LOG2_RST;
      num_exc_r  <= csda_pkg::NUM_EXC_RST;
      num_resp_r <= csda_pkg::NUM_RESP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        csda_pkg::CFG_BLOCK_LOG2: blk_log2_r <= cfg_wdata;
        csda_pkg::CFG_NUM_EXC:    num_exc_r  <= cfg_wdata[2:0];
        csda_pkg::CFG_NUM_RESP:   num_resp_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  csda_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r;
  logic             accept;

  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csda_pkg::ST_CLR:  if (clr_cnt_r == AW'(DEPTH-1)) state_nxt = csda_pkg::ST_IDLE;
      csda_pkg::ST_IDLE: if (accept) state_nxt = csda_pkg::ST_RD;
      csda_pkg::ST_RD:   state_nxt = csda_pkg::ST_SUM;
      csda_pkg::ST_SUM:  state_nxt = csda_pkg::ST_ADD;
      csda_pkg::ST_ADD:  state_nxt = csda_pkg::ST_WB;
      csda_pkg::ST_WB:   state_nxt = accept ? csda_pkg::ST_RD : csda_pkg::ST_IDLE;
      default:           state_nxt = csda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= csda_pkg::ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == csda_pkg::ST_CLR) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Request capture, range check and address
  logic [1:0]                    cmd_r;
  logic                          ok_r;
  logic [AW-1:0]                 addr_r;
  logic signed [SAMPLE_BITS-1:0] a_re_r, a_im_r, b_re_r, b_im_r;
  csda_pkg::prod_ctrl_t          ctrl_r;

  logic [3:0] lg_eff;
  logic [2:0] nrow_cfg, ncol_cfg;
  logic       row_ok, col_ok, bin_ok, req_ok;
  logic [AW-1:0] req_addr;

  always_comb begin
    lg_eff   = (blk_log2_r < 4'd2) ? 4'd2 : blk_log2_r;
    nrow_cfg = (in_spectrum == csda_pkg::SPEC_EXC_EXC ||
                in_spectrum == csda_pkg::SPEC_EXC_RESP) ? num_exc_r : num_resp_r;
    ncol_cfg = (in_spectrum == csda_pkg::SPEC_EXC_EXC ||
                in_spectrum == csda_pkg::SPEC_RESP_EXC) ? num_exc_r : num_resp_r;
    row_ok   = (32'(in_row) < 32'(nrow_cfg)) && (32'(in_row) < MAX_CHANNELS);
    col_ok   = (32'(in_col) < 32'(ncol_cfg)) && (32'(in_col) < MAX_CHANNELS);
    bin_ok   = (32'(in_bin) < MAX_BINS) && ((in_bin >> (lg_eff - 4'd1)) == 9'd0);
    req_ok   = (in_command != csda_pkg::CMD_NONE) && row_ok && col_ok && bin_ok;
    req_addr = AW'(32'(in_spectrum) * (MAX_CHANNELS*MAX_CHANNELS*MAX_BINS)
                 + 32'(in_row) * (MAX_CHANNELS*MAX_BINS)
                 + 32'(in_col) * MAX_BINS
                 + 32'(in_bin));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r           <= in_command;
      ok_r            <= req_ok;
      addr_r          <= req_addr;
      a_re_r          <= in_a_re;
      a_im_r          <= in_a_im;
      b_re_r          <= in_b_re;
      b_im_r          <= in_b_im;
      ctrl_r.bin_zero <= (in_bin == 9'd0);
      ctrl_r.shamt    <= {lg_eff, 1'b0};
    end
  end

  // Products
  logic signed [TW-1:0] term_re, term_im;

  csda_prod #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_prod (
    .clk     (clk),
    .a_re    (a_re_r),
    .a_im    (a_im_r),
    .b_re    (b_re_r),
    .b_im    (b_im_r),
    .ctrl    (ctrl_r),
    .term_re (term_re),
    .term_im (term_im)
  );

  // Entry memory: real part in the upper half, imaginary in the lower half
  logic [MW-1:0]  mem [DEPTH];
  logic [MW-1:0]  rdata_r;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr;
  logic [MW-1:0]  mem_wdata;

  logic signed [ACC_W-1:0] res_re_r, res_im_r;
  logic [1:0]              res_status_r;

  always_comb begin
    busy      = !(state_r == csda_pkg::ST_IDLE || state_r == csda_pkg::ST_WB);
    out_strobe = (state_r == csda_pkg::ST_WB);
    mem_re    = (state_r == csda_pkg::ST_RD);
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = {res_re_r, res_im_r};
    case (state_r)
      csda_pkg::ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      csda_pkg::ST_WB: begin
        mem_we = ok_r && (cmd_r == csda_pkg::CMD_ACC || cmd_r == csda_pkg::CMD_CLEAR);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[addr_r];
  end

  // Accumulate with saturation
  logic signed [ACC_W-1:0] old_re, old_im;
  logic signed [SUM_W-1:0] sum_re, sum_im;
  logic signed [ACC_W-1:0] sat_re, sat_im;
  logic                    sat_hit;
  logic signed [ACC_W-1:0] res_re_nxt, res_im_nxt;
  logic [1:0]              res_status_nxt;

  always_comb begin
    old_re  = rdata_r[MW-1:ACC_W];
    old_im  = rdata_r[ACC_W-1:0];
    sum_re  = SUM_W'(old_re) + SUM_W'(term_re);
    sum_im  = SUM_W'(old_im) + SUM_W'(term_im);
    sat_hit = 1'b0;
    if (sum_re > SAT_MAX) begin
      sat_re  = ACC_MAX;
      sat_hit = 1'b1;
    end else if (sum_re < SAT_MIN) begin
      sat_re  = ACC_MIN;
      sat_hit = 1'b1;
    end else begin
      sat_re = sum_re[ACC_W-1:0];
    end
    if (sum_im > SAT_MAX) begin
      sat_im  = ACC_MAX;
      sat_hit = 1'b1;
    end else if (sum_im < SAT_MIN) begin
      sat_im  = ACC_MIN;
      sat_hit = 1'b1;
    end else begin
      sat_im = sum_im[ACC_W-1:0];
    end

    res_re_nxt     = '0;
    res_im_nxt     = '0;
    res_status_nxt = csda_pkg::STATUS_OK;
    if (!ok_r) begin
      res_status_nxt = csda_pkg::STATUS_RANGE;
    end else begin
      case (cmd_r)
        csda_pkg::CMD_CLEAR: ;
        csda_pkg::CMD_READ: begin
          res_re_nxt = old_re;
          res_im_nxt = old_im;
        end
        default: begin
          res_re_nxt     = sat_re;
          res_im_nxt     = sat_im;
          res_status_nxt = sat_hit ? csda_pkg::STATUS_SAT : csda_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == csda_pkg::ST_ADD) begin
      res_re_r     <= res_re_nxt;
      res_im_r     <= res_im_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  assign out_acc_re = res_re_r;
  assign out_acc_im = res_im_r;
  assign out_status = res_status_r;

  // Checks
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_strobe)
    else $error("result strobe missing four cycles after request");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == csda_pkg::STATUS_RANGE) |->
      (out_acc_re == '0 && out_acc_im == '0))
    else $error("rejected request returned nonzero value");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == csda_pkg::STATUS_SAT) |->
      (out_acc_re == ACC_MAX || out_acc_re == ACC_MIN ||
       out_acc_im == ACC_MAX || out_acc_im == ACC_MIN))
    else $error("saturation flagged without a clamped part");

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csda_pkg::ST_CLR) |=> !out_strobe)
    else $error("result produced during clearing pass");

endmodule

`default_nettype wire

### tb/cross_spectral_density_accumulator_test.sv
// Self-checking testbench for cross_spectral_density_accumulator: drives
// requests and register writes, predicts every entry result, and scores them.
// Depends on csda_pkg and the accumulator RTL only.
`timescale 1ns / 100ps

module cross_spectral_density_accumulator_test;
  import csda_pkg::*;

  localparam int MAX_CH         = MAX_CHANNELS_DEF;
  localparam int MAX_BIN        = MAX_BINS_DEF;
  localparam int SMP_W          = SAMPLE_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 200000;  // longer than the clearing pass after reset
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 165;

  // Register index the package leaves undefined
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  typedef struct packed {
    logic [1:0]       command;
    logic [1:0]       spectrum;
    logic [1:0]       row;
    logic [1:0]       col;
    logic [8:0]       bin;
    logic [SMP_W-1:0] a_re;
    logic [SMP_W-1:0] a_im;
    logic [SMP_W-1:0] b_re;
    logic [SMP_W-1:0] b_im;
  } request_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc_re;
    logic [ACC_W-1:0] acc_im;
    logic [1:0]       status;
  } entry_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_index = '0;
  logic [3:0]              cfg_wdata = '0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_command = '0;
  logic [1:0]              in_spectrum = '0;
  logic [1:0]              in_row = '0;
  logic [1:0]              in_col = '0;
  logic [8:0]              in_bin = '0;
  logic signed [SMP_W-1:0] in_a_re = '0;
  logic signed [SMP_W-1:0] in_a_im = '0;
  logic signed [SMP_W-1:0] in_b_re = '0;
  logic signed [SMP_W-1:0] in_b_im = '0;
  logic                    out_strobe;
  logic signed [ACC_W-1:0] out_acc_re;
  logic signed [ACC_W-1:0] out_acc_im;
  logic [1:0]              out_status;

  // Predictor copy of the registers and the entry store (missing key = zero)
  logic [3:0] cfg_block_log2 = BLOCK_LOG2_RST;
  logic [2:0] cfg_num_exc = NUM_EXC_RST;
  logic [2:0] cfg_num_resp = NUM_RESP_RST;
  longint     entry_re_mem[int];
  longint     entry_im_mem[int];

  entry_result_t expected_results[$];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;

  cross_spectral_density_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_command(in_command), .in_spectrum(in_spectrum), .in_row(in_row), .in_col(in_col),
    .in_bin(in_bin), .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re),
    .in_b_im(in_b_im),
    .out_strobe(out_strobe), .out_acc_re(out_acc_re), .out_acc_im(out_acc_im),
    .out_status(out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int eff_log2();
    int lg;
    lg = cfg_block_log2;
    if (lg < 2) lg = 2;
    if (lg > 15) lg = 15;
    return lg;
  endfunction

  function automatic int bins_in_use();
    int nbins;
    nbins = 1 << (eff_log2() - 1);
    return (nbins > MAX_BIN) ? MAX_BIN : nbins;
  endfunction

  // Rows follow the first channel kind of the spectrum, columns the second
  function automatic int chans_of(input logic [1:0] spec, input bit is_row);
    bit exc_kind;
    exc_kind = is_row ? (spec == SPEC_EXC_EXC || spec == SPEC_EXC_RESP)
                      : (spec == SPEC_EXC_EXC || spec == SPEC_RESP_EXC);
    if (exc_kind) return (cfg_num_exc > MAX_CH) ? MAX_CH : int'(cfg_num_exc);
    return (cfg_num_resp > MAX_CH) ? MAX_CH : int'(cfg_num_resp);
  endfunction

  function automatic longint clamp_acc(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  function automatic entry_result_t predict_entry(input request_t r);
    entry_result_t res;
    int            addr;
    int            shamt;
    longint        ar, ai, br, bi;
    longint        prod_re, prod_im, sum_re, sum_im;
    bit            clamped;
    res.acc_re = '0;
    res.acc_im = '0;
    res.status = STATUS_OK;
    if (r.command == CMD_NONE || r.row >= chans_of(r.spectrum, 1'b1) ||
        r.col >= chans_of(r.spectrum, 1'b0) || r.bin >= bins_in_use()) begin
      res.status = STATUS_RANGE;
      return res;
    end
    addr = ((int'(r.spectrum) * MAX_CH + int'(r.row)) * MAX_CH + int'(r.col)) * MAX_BIN
           + int'(r.bin);
    if (r.command == CMD_CLEAR) begin
      entry_re_mem[addr] = 0;
      entry_im_mem[addr] = 0;
      return res;
    end
    sum_re = entry_re_mem.exists(addr) ? entry_re_mem[addr] : 0;
    sum_im = entry_im_mem.exists(addr) ? entry_im_mem[addr] : 0;
    if (r.command == CMD_ACC) begin
      ar = longint'($signed(r.a_re));
      ai = longint'($signed(r.a_im));
      br = longint'($signed(r.b_re));
      bi = longint'($signed(r.b_im));
      // bin 0 packs DC and Nyquist: multiply the parts separately
      if (r.bin == 0) begin
        prod_re = ar * br;
        prod_im = ai * bi;
      end else begin
        prod_re = ar * br + ai * bi;
        prod_im = ai * br - ar * bi;
      end
      shamt = 2 * eff_log2();
      sum_re = sum_re + (prod_re >>> shamt);
      sum_im = sum_im + (prod_im >>> shamt);
      clamped = (clamp_acc(sum_re) != sum_re) || (clamp_acc(sum_im) != sum_im);
      sum_re = clamp_acc(sum_re);
      sum_im = clamp_acc(sum_im);
      entry_re_mem[addr] = sum_re;
      entry_im_mem[addr] = sum_im;
      if (clamped) res.status = STATUS_SAT;
    end
    res.acc_re = sum_re[ACC_W-1:0];
    res.acc_im = sum_im[ACC_W-1:0];
    return res;
  endfunction

  function automatic logic [SMP_W-1:0] sample_value();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       return {1'b1, {(SMP_W-1){1'b0}}};
      1:       return {1'b0, {(SMP_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return raw[SMP_W-1:0];
    endcase
  endfunction

  // Mostly well-formed requests aimed at a few hot bins, some pure noise
  function automatic request_t make_request();
    request_t r;
    int       pick, nrow, ncol, nbins;
    r.a_re = sample_value();
    r.a_im = sample_value();
    r.b_re = sample_value();
    r.b_im = sample_value();
    if ($urandom_range(99) < 10) begin
      r.command  = 2'($urandom_range(3));
      r.spectrum = 2'($urandom_range(3));
      r.row      = 2'($urandom_range(3));
      r.col      = 2'($urandom_range(3));
      r.bin      = 9'($urandom_range(511));
      return r;
    end
    pick = $urandom_range(99);
    r.command = (pick < 60) ? CMD_ACC : (pick < 85) ? CMD_READ :
                (pick < 95) ? CMD_CLEAR : CMD_NONE;
    r.spectrum = 2'($urandom_range(3));
    nrow = chans_of(r.spectrum, 1'b1);
    ncol = chans_of(r.spectrum, 1'b0);
    r.row = 2'((nrow > 0) ? $urandom_range(nrow - 1) : $urandom_range(3));
    r.col = 2'((ncol > 0) ? $urandom_range(ncol - 1) : $urandom_range(3));
    nbins = bins_in_use();
    case ($urandom_range(3))
      0:       r.bin = '0;
      1:       r.bin = 9'(nbins - 1);
      default: r.bin = 9'($urandom_range(nbins - 1));
    endcase
    return r;
  endfunction

  // Hold the request until the block takes it, then log its expected result
  task automatic send_request(input request_t r);
    entry_result_t predicted;
    start       <= 1'b1;
    in_command  <= r.command;
    in_spectrum <= r.spectrum;
    in_row      <= r.row;
    in_col      <= r.col;
    in_bin      <= r.bin;
    in_a_re     <= r.a_re;
    in_a_im     <= r.a_im;
    in_b_re     <= r.b_re;
    in_b_im     <= r.b_im;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_entry(r);
    expected_results = {expected_results, predicted};
  endtask

  task automatic issue(input logic [1:0] command, input logic [1:0] spectrum,
                       input logic [1:0] row, input logic [1:0] col, input logic [8:0] bin,
                       input logic [SMP_W-1:0] a_re, input logic [SMP_W-1:0] a_im,
                       input logic [SMP_W-1:0] b_re, input logic [SMP_W-1:0] b_im);
    request_t r;
    r = '{command, spectrum, row, col, bin, a_re, a_im, b_re, b_im};
    send_request(r);
  endtask

  task automatic hold_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic apply_config(input logic [3:0] log2_val, input logic [3:0] exc_val,
                              input logic [3:0] resp_val);
    wait_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_LOG2;
    cfg_wdata <= log2_val;
    @(posedge clk);
    cfg_index <= CFG_NUM_EXC;
    cfg_wdata <= exc_val;
    @(posedge clk);
    cfg_index <= CFG_NUM_RESP;
    cfg_wdata <= resp_val;
    @(posedge clk);
    // unmapped index: must leave every register alone
    cfg_index <= CFG_UNMAPPED;
    cfg_wdata <= 4'($urandom);
    @(posedge clk);
    cfg_we         <= 1'b0;
    cfg_block_log2 = log2_val;
    cfg_num_exc    = exc_val[2:0];
    cfg_num_resp   = resp_val[2:0];
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic test_reset_state();
    do @(posedge clk); while (busy !== 1'b0);
    issue(CMD_READ, SPEC_EXC_EXC, 2'd0, 2'd0, 9'd0, '0, '0, '0, '0);
    issue(CMD_READ, SPEC_RESP_RESP, 2'd0, 2'd0, 9'd511, '0, '0, '0, '0);
    issue(CMD_ACC, SPEC_EXC_RESP, 2'd1, 2'd0, 9'd3, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
  endtask

  task automatic test_datapath_ops();
    apply_config(4'd10, 4'd4, 4'd4);
    issue(CMD_ACC, SPEC_EXC_EXC, 2'd0, 2'd0, 9'd0, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    issue(CMD_ACC, SPEC_EXC_EXC, 2'd0, 2'd0, 9'd0, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    issue(CMD_ACC, SPEC_EXC_RESP, 2'd3, 2'd3, 9'd511, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    issue(CMD_ACC, SPEC_RESP_EXC, 2'd1, 2'd2, 9'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    // tiny products: the shift rounds toward minus infinity
    issue(CMD_ACC, SPEC_RESP_RESP, 2'd2, 2'd1, 9'd256, 16'h0001, 16'hFFFF, 16'h0001, 16'h0001);
    issue(CMD_READ, SPEC_EXC_EXC, 2'd0, 2'd0, 9'd0, '0, '0, '0, '0);
    issue(CMD_CLEAR, SPEC_EXC_EXC, 2'd0, 2'd0, 9'd0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    issue(CMD_READ, SPEC_EXC_EXC, 2'd0, 2'd0, 9'd0, '0, '0, '0, '0);
    issue(CMD_NONE, SPEC_EXC_RESP, 2'd3, 2'd3, 9'd511, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    issue(CMD_READ, SPEC_EXC_RESP, 2'd3, 2'd3, 9'd511, '0, '0, '0, '0);
  endtask

  task automatic test_config_limits();
    // log2 of 0 acts as 2: two bins, shift of 4
    apply_config(4'd0, 4'd2, 4'd3);
    issue(CMD_ACC, SPEC_EXC_RESP, 2'd1, 2'd2, 9'd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    issue(CMD_ACC, SPEC_EXC_RESP, 2'd1, 2'd2, 9'd2, 16'h7FFF, 16'h0001, 16'h0002, 16'h0003);
    issue(CMD_ACC, SPEC_RESP_EXC, 2'd2, 2'd1, 9'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
    issue(CMD_READ, SPEC_RESP_EXC, 2'd3, 2'd1, 9'd0, '0, '0, '0, '0);
    issue(CMD_READ, SPEC_EXC_EXC, 2'd1, 2'd2, 9'd0, '0, '0, '0, '0);
    // no response channels: every response entry is out of range
    apply_config(4'd15, 4'd7, 4'd0);
    issue(CMD_ACC, SPEC_EXC_EXC, 2'd3, 2'd3, 9'd511, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    issue(CMD_ACC, SPEC_RESP_RESP, 2'd0, 2'd0, 9'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    issue(CMD_CLEAR, SPEC_EXC_RESP, 2'd0, 2'd0, 9'd0, '0, '0, '0, '0);
    // upper data bit set: only the low three bits count
    apply_config(4'd2, 4'd12, 4'd9);
    issue(CMD_ACC, SPEC_RESP_EXC, 2'd0, 2'd3, 9'd1, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
    issue(CMD_READ, SPEC_RESP_EXC, 2'd1, 2'd3, 9'd1, '0, '0, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [3:0] log2_tab[RANDOM_PHASES] = '{4'd10, 4'd2, 4'd15, 4'd0, 4'd12, 4'd5, 4'd1, 4'd11};
    logic [3:0] exc_tab[RANDOM_PHASES]  = '{4'd4, 4'd4, 4'd1, 4'd4, 4'd3, 4'd7, 4'd2, 4'd12};
    logic [3:0] resp_tab[RANDOM_PHASES] = '{4'd4, 4'd4, 4'd4, 4'd1, 4'd2, 4'd6, 4'd3, 4'd9};
    int         idle_tab[4] = '{0, 72, 0, 25};
    int         idle_pct;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      apply_config(log2_tab[ph], exc_tab[ph], resp_tab[ph]);
      idle_pct = idle_tab[ph % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while ($urandom_range(99) < idle_pct) hold_cycle();
        // now and then let everything drain before the next request
        if ($urandom_range(99) < 2) wait_results();
        send_request(make_request());
      end
    end
  endtask

  always @(posedge clk) begin
    entry_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result re=%h im=%h status=%0d",
                                out_acc_re, out_acc_im, out_status));
      end else begin
        want = expected_results.pop_front();
        if (out_acc_re !== want.acc_re)
          flag_mismatch($sformatf("acc_re expected %h got %h", want.acc_re, out_acc_re));
        if (out_acc_im !== want.acc_im)
          flag_mismatch($sformatf("acc_im expected %h got %h", want.acc_im, out_acc_im));
        if (out_status !== want.status)
          flag_mismatch($sformatf("status expected %0d got %0d", want.status, out_status));
      end
    end
  end

  // Count cycles with neither a request taken nor a result strobed
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_datapath_ops();
    test_config_limits();
    test_random_traffic();
    wait_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/csda_pkg.sv
rtl/csda_prod.sv
rtl/cross_spectral_density_accumulator.sv
tb/cross_spectral_density_accumulator_test.sv
